FILE: rtl/core/plid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plid_pkg
// Shared types, widths and codes for the positional list block.
// ----------------------------------------------------------------------------
package plid_pkg;

    localparam int CAPACITY      = 16;
    localparam int IDX_W         = $clog2(CAPACITY);
    localparam int LEN_W         = $clog2(CAPACITY + 1);
    localparam int POS_W         = 8;
    localparam int VALUE_W       = 32;
    localparam int CMD_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_INDEX_W = 4;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READOUT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]          op;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] value;
    } t_cmd;

endpackage

FILE: rtl/core/positional_list_insert_delete.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_insert_delete
// Ordered list of up to 16 signed 32-bit values with positional insert,
// delete and full read-out.
// ----------------------------------------------------------------------------
// Commands enter through a queue-style port (push/full) and land in a
// two-deep command queue; results leave through a one-word result register
// (empty/pop). Insert and delete each update the whole list at once in the
// back end, since all list cells shift in parallel; a read-out gives one
// result word per stored entry (a single ST_EMPTY word when the list is
// empty), paced by the single read port over the cell array. A command
// passes from the command queue into the result register before its word
// is on the result ports. Command 3 is accepted and produces no result.
// ----------------------------------------------------------------------------
module positional_list_insert_delete
    import plid_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [CMD_W-1:0]            i_command,
    input  logic [POS_W-1:0]            i_position,
    input  logic signed [VALUE_W-1:0]   i_value,
    output logic                        empty,
    input  logic                        pop,
    output logic [STATUS_W-1:0]         o_status,
    output logic signed [VALUE_W-1:0]   o_entry_value,
    output logic [ENTRY_INDEX_W-1:0]    o_entry_index,
    output logic                        o_last
);

    logic q_full;
    logic q_wr;
    t_cmd q_wr_data;
    logic q_rd;
    logic q_valid;
    t_cmd q_rd_data;

    plid_front u_front (
        .i_push     (push),
        .i_command  (i_command),
        .i_position (i_position),
        .i_value    (i_value),
        .i_q_full   (q_full),
        .o_full     (full),
        .o_q_wr     (q_wr),
        .o_q_data   (q_wr_data)
    );

    plid_cmd_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_wr),
        .i_wr_data (q_wr_data),
        .i_rd      (q_rd),
        .o_full    (q_full),
        .o_valid   (q_valid),
        .o_rd_data (q_rd_data)
    );

    plid_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_data      (q_rd_data),
        .o_q_rd        (q_rd),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_status      (o_status),
        .o_entry_value (o_entry_value),
        .o_entry_index (o_entry_index),
        .o_last        (o_last)
    );

endmodule

FILE: rtl/core/plid_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plid_front
// Input side: accepts words, drops unused commands, feeds the command queue.
// ----------------------------------------------------------------------------
module plid_front
    import plid_pkg::*;
(
    input  logic                      i_push,
    input  logic [CMD_W-1:0]          i_command,
    input  logic [POS_W-1:0]          i_position,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_q_full,
    output logic                      o_full,
    output logic                      o_q_wr,
    output t_cmd                      o_q_data
);

    logic accept;

    assign o_full = i_q_full;
    assign accept = i_push && !i_q_full;

    // unused command yields no result: drop it here
    always_comb begin
        o_q_wr = 1'b0;
        case (i_command)
            CMD_INSERT, CMD_DELETE, CMD_READOUT: o_q_wr = accept;
            CMD_UNUSED:                          o_q_wr = 1'b0;
            default:                             o_q_wr = 1'b0;
        endcase
    end

    assign o_q_data.op       = i_command;
    assign o_q_data.position = i_position;
    assign o_q_data.value    = i_value;

endmodule

FILE: rtl/core/plid_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plid_cmd_queue
// Short queue of classified commands between front and back.
// ----------------------------------------------------------------------------
module plid_cmd_queue
    import plid_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_wr_data,
    input  logic i_rd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_rd_data
);

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_wr;
    logic              do_rd;

    assign o_full    = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_rd_data = r_slot[r_rd_ptr];
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_slot[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/core/plid_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plid_back
// Execution side: holds the list cells, carries out insert, delete and
// read-out, and drives the result register.
// ----------------------------------------------------------------------------
module plid_back
    import plid_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  t_cmd                        i_q_data,
    output logic                        o_q_rd,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [STATUS_W-1:0]         o_status,
    output logic signed [VALUE_W-1:0]   o_entry_value,
    output logic [ENTRY_INDEX_W-1:0]    o_entry_index,
    output logic                        o_last
);

    logic signed [VALUE_W-1:0] r_cell [CAPACITY];
    logic signed [VALUE_W-1:0] n_cell [CAPACITY];
    logic [LEN_W-1:0]          r_len;
    logic [LEN_W-1:0]          n_len;
    logic [IDX_W-1:0]          r_idx;
    logic [IDX_W-1:0]          n_idx;

    logic                        r_out_valid;
    logic [STATUS_W-1:0]         r_status;
    logic signed [VALUE_W-1:0]   r_value;
    logic [ENTRY_INDEX_W-1:0]    r_index;
    logic                        r_last;
    logic                        n_out_valid;
    logic [STATUS_W-1:0]         n_status;
    logic signed [VALUE_W-1:0]   n_value;
    logic [ENTRY_INDEX_W-1:0]    n_index;
    logic                        n_last;

    logic                        out_free;
    logic                        go;
    logic [LEN_W-1:0]            ins_pos;
    logic [LEN_W-1:0]            del_pos;
    logic                        rd_final;

    assign out_free = !r_out_valid || i_pop;
    assign go       = out_free && i_q_valid;

    // insert past the end appends
    assign ins_pos  = (i_q_data.position >= POS_W'(r_len)) ? r_len
                                                           : LEN_W'(i_q_data.position);
    assign del_pos  = LEN_W'(i_q_data.position);
    assign rd_final = (LEN_W'(r_idx) + LEN_W'(1) >= r_len);

    always_comb begin
        n_cell      = r_cell;
        n_len       = r_len;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_pop;
        n_status    = r_status;
        n_value     = r_value;
        n_index     = r_index;
        n_last      = r_last;
        o_q_rd      = 1'b0;
        if (go) begin
            n_out_valid = 1'b1;
            n_status    = ST_OK;
            n_value     = '0;
            n_index     = '0;
            n_last      = 1'b1;
            case (i_q_data.op)
                CMD_INSERT: begin
                    o_q_rd = 1'b1;
                    if (r_len == LEN_W'(CAPACITY)) begin
                        n_status = ST_FULL;
                    end else begin
                        for (int i = 0; i < CAPACITY; i++) begin
                            if (LEN_W'(i) == ins_pos) begin
                                n_cell[i] = i_q_data.value;
                            end else if (LEN_W'(i) > ins_pos) begin
                                n_cell[i] = r_cell[(i == 0) ? 0 : i - 1];
                            end
                        end
                        n_len = r_len + 1'b1;
                    end
                end
                CMD_DELETE: begin
                    o_q_rd = 1'b1;
                    if (r_len == '0) begin
                        n_status = ST_EMPTY;
                    end else if (i_q_data.position >= POS_W'(r_len)) begin
                        n_status = ST_BADPOS;
                    end else begin
                        for (int i = 0; i < CAPACITY - 1; i++) begin
                            if (LEN_W'(i) >= del_pos) begin
                                n_cell[i] = r_cell[i + 1];
                            end
                        end
                        n_len = r_len - 1'b1;
                    end
                end
                CMD_READOUT: begin
                    if (r_len == '0) begin
                        o_q_rd   = 1'b1;
                        n_status = ST_EMPTY;
                    end else begin
                        // one entry per word; hold the command until the last
                        n_value = r_cell[r_idx];
                        n_index = ENTRY_INDEX_W'(r_idx);
                        n_last  = rd_final;
                        if (rd_final) begin
                            o_q_rd = 1'b1;
                            n_idx  = '0;
                        end else begin
                            n_idx  = r_idx + 1'b1;
                        end
                    end
                end
                default: begin
                    o_q_rd      = 1'b1;
                    n_out_valid = r_out_valid && !i_pop;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell   <= n_cell;
        r_status <= n_status;
        r_value  <= n_value;
        r_index  <= n_index;
        r_last   <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_status      = r_status;
    assign o_entry_value = r_value;
    assign o_entry_index = r_index;
    assign o_last        = r_last;

endmodule
